[sv/bdbs_pkg.sv]
// Shared types and constants for the button debounce and blink sequencer.
package bdbs_pkg;

    localparam int MODE_W   = 2;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int RUN_W    = 8;
    localparam int PERIOD_W = 16;
    localparam int STEPS_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLINK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_STEPS  = 2'd2;

    localparam logic [RUN_W-1:0]    RST_STABLE_COUNT = 8'd5;
    localparam logic [PERIOD_W-1:0] RST_BLINK_PERIOD = 16'd100;
    localparam logic [STEPS_W-1:0]  RST_BLINK_STEPS  = 8'd6;

    // One strobe per event kind, high in the cycle the event is applied.
    typedef struct packed {
        logic sample;
        logic blink;
        logic report;
    } t_step_ctl;

endpackage

[sv/bdbs_in_if.sv]
// Input event channel: valid/ready handshake with the event payload.
interface bdbs_in_if;
    import bdbs_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic                button_level;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output mode, output button_level, output now_ms,
                    input ready);
    modport sink   (input valid, input mode, input button_level, input now_ms,
                    output ready);
endinterface

[sv/bdbs_out_if.sv]
// Result channel: valid/ready handshake with LED levels and status report.
interface bdbs_out_if;
    import bdbs_pkg::*;

    logic               valid;
    logic               ready;
    logic               led_one;
    logic               led_two;
    logic               led_three;
    logic               report_valid;
    logic [COUNT_W-1:0] press_total;

    modport source (output valid, output led_one, output led_two, output led_three,
                    output report_valid, output press_total, input ready);
    modport sink   (input valid, input led_one, input led_two, input led_three,
                    input report_valid, input press_total, output ready);
endinterface

[sv/bdbs_debounce.sv]
// Button debouncer: saturating run counter, press latch and LED1 toggle.
module bdbs_debounce
    import bdbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_step_ctl        i_step,
    input  logic             i_button_level,
    input  logic [RUN_W-1:0] i_stable_count,
    output logic             o_press_accept,
    output logic             o_led_one_next
);

    logic [RUN_W-1:0] r_run, n_run;
    logic             r_last, n_last;
    logic             r_latched, n_latched;
    logic             r_led, n_led;
    logic             pressed;
    logic [RUN_W-1:0] run_inc;
    logic             accept;

    assign pressed = ~i_button_level;

    always_comb begin
        n_run     = r_run;
        n_last    = r_last;
        n_latched = r_latched;
        n_led     = r_led;
        accept    = 1'b0;
        run_inc   = (r_run < i_stable_count) ? r_run + 1'b1 : r_run;
        if (i_step.sample) begin
            if (pressed != r_last) begin
                n_run  = '0;
                n_last = pressed;
            end else begin
                n_run = run_inc;
                if (run_inc == i_stable_count && pressed && !r_latched) begin
                    n_latched = 1'b1;
                    n_led     = ~r_led;
                    accept    = 1'b1;
                end
            end
            // release re-arms the detector
            if (!pressed) begin
                n_latched = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_last    <= 1'b0;
            r_latched <= 1'b0;
            r_led     <= 1'b0;
        end else begin
            r_run     <= n_run;
            r_last    <= n_last;
            r_latched <= n_latched;
            r_led     <= n_led;
        end
    end

    assign o_press_accept = accept;
    assign o_led_one_next = n_led;

endmodule

[sv/bdbs_blink.sv]
// Blink sequencer: pending press, press counter and LED2 step timing.
module bdbs_blink
    import bdbs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_step_ctl           i_step,
    input  logic                i_press_accept,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [PERIOD_W-1:0] i_blink_period,
    input  logic [STEPS_W-1:0]  i_blink_steps,
    output logic [COUNT_W-1:0]  o_press_count,
    output logic                o_led_two_next
);

    logic               r_pending, n_pending;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_active, n_active;
    logic [STEPS_W-1:0] r_index, n_index;
    logic [TIME_W-1:0]  r_last_time, n_last_time;
    logic               r_led, n_led;

    logic               act0, led0;
    logic [STEPS_W-1:0] idx0, idx1;
    logic [TIME_W-1:0]  last0, elapsed;

    always_comb begin
        n_pending   = r_pending;
        n_count     = r_count;
        n_active    = r_active;
        n_index     = r_index;
        n_last_time = r_last_time;
        n_led       = r_led;

        // a pending press restarts the sequence
        act0    = r_pending | r_active;
        idx0    = r_pending ? '0 : r_index;
        last0   = r_pending ? i_now_ms : r_last_time;
        led0    = r_pending | r_led;
        elapsed = i_now_ms - last0;
        idx1    = idx0 + 1'b1;

        if (i_step.sample && i_press_accept) begin
            n_pending = 1'b1;
        end
        if (i_step.blink) begin
            n_pending   = 1'b0;
            n_count     = r_pending ? r_count + 1'b1 : r_count;
            n_active    = act0;
            n_index     = idx0;
            n_last_time = last0;
            n_led       = led0;
            if (act0 && elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, i_blink_period}) begin
                n_last_time = i_now_ms;
                if (idx1 >= i_blink_steps) begin
                    n_active = 1'b0;
                    n_index  = '0;
                    n_led    = 1'b0;
                end else begin
                    n_index = idx1;
                    n_led   = ~led0;
                end
            end
        end
        if (i_step.report) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_index     <= '0;
            r_last_time <= '0;
            r_led       <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_count     <= n_count;
            r_active    <= n_active;
            r_index     <= n_index;
            r_last_time <= n_last_time;
            r_led       <= n_led;
        end
    end

    assign o_press_count  = r_count;
    assign o_led_two_next = n_led;

endmodule

[sv/button_debounce_blink_sequencer.sv]
// Top level: input register, event logic and result register.
// Takes one event per clock: an accepted beat lands in the input register, is applied to
// the debounce and blink state as it moves into the result register, and is offered on
// the result channel from the result register. Throughput is one beat per cycle while
// the result side keeps taking beats; a stalled result holds the input register and then
// input ready. Every event gives exactly one result showing the LED levels after it.
// Configuration writes take effect on the next cycle and are meant for idle periods.
module button_debounce_blink_sequencer
    import bdbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bdbs_in_if.sink               i_in,
    bdbs_out_if.source            o_out
);

    logic [RUN_W-1:0]    r_stable_count;
    logic [PERIOD_W-1:0] r_blink_period;
    logic [STEPS_W-1:0]  r_blink_steps;

    logic               r_in_valid;
    logic [MODE_W-1:0]  r_mode;
    logic               r_button;
    logic [TIME_W-1:0]  r_now;

    logic               r_out_valid;
    logic               r_led_one, r_led_two, r_led_three;
    logic               r_report;
    logic [COUNT_W-1:0] r_total;

    logic               advance;
    t_step_ctl          step;
    logic               press_accept;
    logic               led_one_next, led_two_next;
    logic [COUNT_W-1:0] press_count;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        step = '0;
        if (advance) begin
            unique case (r_mode)
                MODE_SAMPLE: step.sample = 1'b1;
                MODE_BLINK:  step.blink  = 1'b1;
                MODE_REPORT: step.report = 1'b1;
                default:     step = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_count <= RST_STABLE_COUNT;
            r_blink_period <= RST_BLINK_PERIOD;
            r_blink_steps  <= RST_BLINK_STEPS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STABLE_COUNT: r_stable_count <= i_cfg_data[RUN_W-1:0];
                REG_BLINK_PERIOD: r_blink_period <= i_cfg_data[PERIOD_W-1:0];
                REG_BLINK_STEPS:  r_blink_steps  <= i_cfg_data[STEPS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_mode   <= i_in.mode;
            r_button <= i_in.button_level;
            r_now    <= i_in.now_ms;
        end
    end

    bdbs_debounce u_debounce (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_button_level (r_button),
        .i_stable_count (r_stable_count),
        .o_press_accept (press_accept),
        .o_led_one_next (led_one_next)
    );

    bdbs_blink u_blink (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_press_accept (press_accept),
        .i_now_ms       (r_now),
        .i_blink_period (r_blink_period),
        .i_blink_steps  (r_blink_steps),
        .o_press_count  (press_count),
        .o_led_two_next (led_two_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_led_three <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (step.report) begin
                r_led_three <= ~r_led_three;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_led_one <= led_one_next;
            r_led_two <= led_two_next;
            r_report  <= step.report;
            r_total   <= step.report ? press_count : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.led_one      = r_led_one;
    assign o_out.led_two      = r_led_two;
    assign o_out.led_three    = r_led_three;
    assign o_out.report_valid = r_report;
    assign o_out.press_total  = r_total;

endmodule
